/* rtl/core/cfwr_pkg.sv */
// ----------------------------------------------------------------------------
// cfwr_pkg
// Shared types and constants for the ring-buffer queue with match-and-replace.
// ----------------------------------------------------------------------------
package cfwr_pkg;

  localparam int unsigned SlotsDflt = 16;
  localparam int unsigned WordW     = 32;

  typedef enum logic [1:0] {
    KIND_ENQ = 2'd0,
    KIND_DEQ = 2'd1,
    KIND_CLR = 2'd2,
    KIND_REP = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic    enq;         // write word at tail, advance tail
    logic    deq;         // advance head
    logic    clr;         // both indices back to zero
    logic    scan_start;  // latch match/replacement, scan pointer to head
    logic    scan_step;   // compare/write current slot, move to next
    logic    res_load;    // load result register
    logic    res_use_rd;  // result word comes from the storage read
    status_e res_status;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

/* rtl/core/circular_fifo_with_replace_core.sv */
// ----------------------------------------------------------------------------
// circular_fifo_with_replace_core
// Ring-buffer queue of 32-bit words with enqueue, dequeue, clear and replace.
// ----------------------------------------------------------------------------
// One request is handled at a time. Enqueue, clear, and a dequeue or replace on
// an empty queue finish in the cycle they are accepted; a dequeue that removes
// a word finishes in S_DEQ because the storage read is registered; replace
// walks the N queued words (N up to SLOTS-1) in S_SCAN, as the single-port-read
// storage is scanned one word per cycle, compare and write back following
// each read. The result sits in an output register, so it shows on the
// master side the cycle after the request completes, and a new request is
// taken as soon as that register is free or being drained.
// Storage holds SLOTS words, at most SLOTS-1 queued.
module circular_fifo_with_replace_core #(
  parameter int unsigned SLOTS = cfwr_pkg::SlotsDflt
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] value, [63:32] match_value
  input  logic [1:0]  s_axis_tuser,   // [1:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] data_out
  output logic [7:0]  m_axis_tuser    // [1:0] status, [2] is_empty, [3] is_full
);
  import cfwr_pkg::*;

  cmd_t    cmd;
  sts_t    sts;
  status_e status;
  logic    empty, full;

  cfwr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .kind_i        (kind_e'(s_axis_tuser)),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  cfwr_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .value_i       (s_axis_tdata[31:0]),
    .match_i       (s_axis_tdata[63:32]),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .data_o        (m_axis_tdata),
    .status_o      (status),
    .empty_o       (empty),
    .full_o        (full)
  );

  assign m_axis_tuser = {4'b0000, full, empty, status};

endmodule

/* rtl/core/cfwr_ctrl.sv */
// ----------------------------------------------------------------------------
// cfwr_ctrl
// Sequencer: decodes each request and steps dequeue and replace scans.
// ----------------------------------------------------------------------------
module cfwr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  cfwr_pkg::kind_e  kind_i,
  input  cfwr_pkg::sts_t   sts_i,
  output cfwr_pkg::cmd_t   cmd_o
);
  import cfwr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DEQ  = 3'b010,
    S_SCAN = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   acc;

  assign s_axis_tready = (state_q == S_IDLE) && sts_i.out_free;
  assign acc           = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.res_status = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          case (kind_i)
            KIND_ENQ: begin
              cmd_o.enq        = !sts_i.full;
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = sts_i.full ? ST_FULL : ST_OK;
            end
            KIND_DEQ: begin
              if (sts_i.empty) begin
                cmd_o.res_load   = 1'b1;
                cmd_o.res_status = ST_EMPTY;
              end else begin
                // storage read of head is under way
                state_d = S_DEQ;
              end
            end
            KIND_CLR: begin
              cmd_o.clr      = 1'b1;
              cmd_o.res_load = 1'b1;
            end
            KIND_REP: begin
              if (sts_i.empty) begin
                cmd_o.res_load = 1'b1;
              end else begin
                cmd_o.scan_start = 1'b1;
                state_d          = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      S_DEQ: begin
        cmd_o.deq        = 1'b1;
        cmd_o.res_load   = 1'b1;
        cmd_o.res_use_rd = 1'b1;
        state_d          = S_IDLE;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/core/cfwr_dpath.sv */
// ----------------------------------------------------------------------------
// cfwr_dpath
// Indices, word storage, replace scan pointer and the result register.
// ----------------------------------------------------------------------------
module cfwr_dpath #(
  parameter int unsigned SLOTS = cfwr_pkg::SlotsDflt
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cfwr_pkg::cmd_t                cmd_i,
  output cfwr_pkg::sts_t                sts_o,
  input  logic [cfwr_pkg::WordW-1:0]    value_i,
  input  logic [cfwr_pkg::WordW-1:0]    match_i,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [cfwr_pkg::WordW-1:0]    data_o,
  output cfwr_pkg::status_e             status_o,
  output logic                          empty_o,
  output logic                          full_o
);
  import cfwr_pkg::*;

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  function automatic logic [IdxW-1:0] nxt(input logic [IdxW-1:0] i);
    return (i == IdxW'(SLOTS - 1)) ? '0 : i + IdxW'(1);
  endfunction

  logic [WordW-1:0] mem [SLOTS];

  logic [IdxW-1:0]  head_q, head_d, tail_q, tail_d, ptr_q, ptr_nx, rd_addr, wr_addr;
  logic [WordW-1:0] rd_data_q, wr_data, match_q, value_q;
  logic             wr_en, hit;
  logic             out_valid_q;
  logic [WordW-1:0] out_data_q;
  status_e          out_status_q;
  logic             out_empty_q, out_full_q;

  assign ptr_nx  = nxt(ptr_q);
  assign hit     = (rd_data_q == match_q);
  assign rd_addr = cmd_i.scan_step ? ptr_nx : head_q;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    if (cmd_i.clr) begin
      head_d = '0;
      tail_d = '0;
    end else begin
      if (cmd_i.deq) head_d = nxt(head_q);
      if (cmd_i.enq) tail_d = nxt(tail_q);
    end
  end

  // enqueue and replace writes never fall in the same cycle
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = tail_q;
    wr_data = value_i;
    if (cmd_i.enq) begin
      wr_en = 1'b1;
    end else if (cmd_i.scan_step && hit) begin
      wr_en   = 1'b1;
      wr_addr = ptr_q;
      wr_data = value_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      if (cmd_i.res_load)     out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) begin
      ptr_q   <= head_q;
      match_q <= match_i;
      value_q <= value_i;
    end else if (cmd_i.scan_step) begin
      ptr_q <= ptr_nx;
    end
    if (cmd_i.res_load) begin
      out_data_q   <= cmd_i.res_use_rd ? rd_data_q : '0;
      out_status_q <= cmd_i.res_status;
      out_empty_q  <= (head_d == tail_d);
      out_full_q   <= (nxt(tail_d) == head_d);
    end
  end

  assign sts_o.empty     = (head_q == tail_q);
  assign sts_o.full      = (nxt(tail_q) == head_q);
  assign sts_o.scan_last = (ptr_nx == tail_q);
  assign sts_o.out_free  = !out_valid_q || m_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign data_o        = out_data_q;
  assign status_o      = out_status_q;
  assign empty_o       = out_empty_q;
  assign full_o        = out_full_q;

endmodule

/* rtl/core/cfwr_chk.sv */
// ----------------------------------------------------------------------------
// cfwr_chk
// Port-level checks on the result stream, bound to the core.
// ----------------------------------------------------------------------------
module cfwr_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [7:0]  m_axis_tuser
);
  import cfwr_pkg::*;

  // stalled result stays up and unchanged
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // empty and full can never both hold with two or more slots
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[2] && m_axis_tuser[3]))
    else $error("empty and full both set");

  // a full or empty reject status comes with the matching is_full or is_empty flag
  a_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tuser[1:0] != ST_FULL  || m_axis_tuser[3]) &&
      (m_axis_tuser[1:0] != ST_EMPTY || m_axis_tuser[2]))
    else $error("reject status disagrees with flags");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[1:0] != ST_OK) |-> (m_axis_tdata == '0))
    else $error("rejected request returned a word");

endmodule

bind circular_fifo_with_replace_core cfwr_chk u_cfwr_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
